@@ rtl/sorted_priority_queue_macros.svh @@
// Assertion macros used by the checker file (spq_checker.sv).
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: next-cycle check failed");

`endif

@@ rtl/spq_pkg.sv @@
package spq_pkg;

  typedef enum logic [2:0] {
    FUNC_INSERT     = 3'd0,
    FUNC_REMOVE     = 3'd1,
    FUNC_PEEK_FRONT = 3'd2,
    FUNC_PEEK_TAIL  = 3'd3,
    FUNC_CLEAR      = 3'd4
  } func_e;

  localparam int unsigned FuncBits = 3;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle while the output is not stalled; every cell of the
// chain compares and shifts in the same cycle; the output register frees as it drains.
// Reset: rst_ni (async, active low) empties the queue and drops the output
// beat; the cell contents are not cleared and are never read while unused.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned RANK_BITS    = 16,
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1),
  localparam int unsigned IN_BITS  = spq_pkg::FuncBits + RANK_BITS + PAYLOAD_BITS,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = 2 + RANK_BITS + PAYLOAD_BITS + CNT_W,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // func, in_rank, in_payload (from bit 0 up), zero padded
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // status, out_rank, out_payload, entry_count, is_empty (from bit 0 up), zero padded
  output logic [OUT_W-1:0] m_axis_tdata_o
);
  import spq_pkg::*;

  func_e                   func;
  logic [RANK_BITS-1:0]    in_rank;
  logic [PAYLOAD_BITS-1:0] in_payload;
  logic                    accept;

  logic [CNT_W-1:0]        count_q, count_d;
  logic [RANK_BITS-1:0]    tail_rank_q, tail_rank_d;
  logic [PAYLOAD_BITS-1:0] tail_payload_q, tail_payload_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]     out_q, out_d;

  cell_ctrl_t              ctrl;
  logic                    status;
  logic [RANK_BITS-1:0]    res_rank;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic                    not_full, not_empty, any_lt;

  logic [RANK_BITS-1:0]    rank_w    [CAPACITY];
  logic [PAYLOAD_BITS-1:0] payload_w [CAPACITY];
  logic [CAPACITY-1:0]     keep_w;
  logic [CAPACITY-1:0]     lt_w;

  assign func       = func_e'(s_axis_tdata_i[FuncBits-1:0]);
  assign in_rank    = s_axis_tdata_i[FuncBits +: RANK_BITS];
  assign in_payload = s_axis_tdata_i[FuncBits+RANK_BITS +: PAYLOAD_BITS];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign not_full  = (count_q < CNT_W'(CAPACITY));
  assign not_empty = (count_q != '0);
  assign any_lt    = |lt_w;

  always_comb begin
    ctrl           = '0;
    status         = StatusFail;
    res_rank       = '0;
    res_payload    = '0;
    count_d        = count_q;
    tail_rank_d    = tail_rank_q;
    tail_payload_d = tail_payload_q;
    unique case (func)
      FUNC_INSERT: begin
        if (not_full) begin
          ctrl.ins = accept;
          status   = StatusOk;
          count_d  = count_q + CNT_W'(1);
          // New entry lands at the back when nothing held ranks below it.
          if (!any_lt) begin
            tail_rank_d    = in_rank;
            tail_payload_d = in_payload;
          end
        end
      end
      FUNC_REMOVE: begin
        if (not_empty) begin
          ctrl.rem    = accept;
          status      = StatusOk;
          res_rank    = rank_w[0];
          res_payload = payload_w[0];
          count_d     = count_q - CNT_W'(1);
        end
      end
      FUNC_PEEK_FRONT: begin
        if (not_empty) begin
          status      = StatusOk;
          res_rank    = rank_w[0];
          res_payload = payload_w[0];
        end
      end
      FUNC_PEEK_TAIL: begin
        if (not_empty) begin
          status      = StatusOk;
          res_rank    = tail_rank_q;
          res_payload = tail_payload_q;
        end
      end
      FUNC_CLEAR: begin
        if (not_empty) begin
          status  = StatusOk;
          count_d = '0;
        end
      end
      default: begin
        status = StatusFail;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                    prev_keep;
      logic [RANK_BITS-1:0]    left_rank, right_rank;
      logic [PAYLOAD_BITS-1:0] left_payload, right_payload;

      if (gi == 0) begin : g_head
        assign prev_keep    = 1'b1;
        assign left_rank    = in_rank;
        assign left_payload = in_payload;
      end else begin : g_body
        assign prev_keep    = keep_w[gi-1];
        assign left_rank    = rank_w[gi-1];
        assign left_payload = payload_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_rank    = rank_w[gi];
        assign right_payload = payload_w[gi];
      end else begin : g_inner
        assign right_rank    = rank_w[gi+1];
        assign right_payload = payload_w[gi+1];
      end

      spq_cell #(
        .IDX          (gi),
        .RANK_BITS    (RANK_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CNT_W        (CNT_W)
      ) u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .count_i         (count_q),
        .new_rank_i      (in_rank),
        .new_payload_i   (in_payload),
        .prev_keep_i     (prev_keep),
        .left_rank_i     (left_rank),
        .left_payload_i  (left_payload),
        .right_rank_i    (right_rank),
        .right_payload_i (right_payload),
        .rank_o          (rank_w[gi]),
        .payload_o       (payload_w[gi]),
        .keep_o          (keep_w[gi]),
        .lt_o            (lt_w[gi])
      );
    end
  endgenerate

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_d       = {(count_d == '0), count_d, res_payload, res_rank, status};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the tail copy and the result beat; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      tail_rank_q    <= tail_rank_d;
      tail_payload_q <= tail_payload_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(out_q);

endmodule

@@ rtl/spq_cell.sv @@
module spq_cell #(
  parameter int unsigned IDX          = 0,
  parameter int unsigned RANK_BITS    = 16,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned CNT_W        = 5
) (
  input  logic                    clk_i,
  input  spq_pkg::cell_ctrl_t     ctrl_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [RANK_BITS-1:0]    new_rank_i,
  input  logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  logic                    prev_keep_i,
  input  logic [RANK_BITS-1:0]    left_rank_i,
  input  logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  logic [RANK_BITS-1:0]    right_rank_i,
  input  logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic [RANK_BITS-1:0]    rank_o,
  output logic [PAYLOAD_BITS-1:0] payload_o,
  output logic                    keep_o,
  output logic                    lt_o
);
  import spq_pkg::*;

  logic [RANK_BITS-1:0]    rank_q, rank_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                    occupied;

  assign occupied = (count_i > CNT_W'(IDX));
  // Entry stays put on insert when it ranks at or above the new one.
  assign keep_o   = occupied && (rank_q >= new_rank_i);
  assign lt_o     = occupied && (rank_q < new_rank_i);

  always_comb begin
    rank_d    = rank_q;
    payload_d = payload_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        if (prev_keep_i) begin
          rank_d    = new_rank_i;
          payload_d = new_payload_i;
        end else begin
          rank_d    = left_rank_i;
          payload_d = left_payload_i;
        end
      end
    end else if (ctrl_i.rem) begin
      rank_d    = right_rank_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q    <= rank_d;
    payload_q <= payload_d;
  end

  assign rank_o    = rank_q;
  assign payload_o = payload_q;

endmodule

@@ rtl/spq_checker.sv @@
`include "sorted_priority_queue_macros.svh"

module spq_checker #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned RANK_BITS    = 16,
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1),
  localparam int unsigned IN_BITS  = spq_pkg::FuncBits + RANK_BITS + PAYLOAD_BITS,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = 2 + RANK_BITS + PAYLOAD_BITS + CNT_W,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [IN_W-1:0]  s_axis_tdata_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);
  import spq_pkg::*;

  logic                    o_status;
  logic [RANK_BITS-1:0]    o_rank;
  logic [PAYLOAD_BITS-1:0] o_payload;
  logic [CNT_W-1:0]        o_count;
  logic                    o_empty;
  logic                    in_beat;

  assign o_status  = m_axis_tdata_o[0];
  assign o_rank    = m_axis_tdata_o[1 +: RANK_BITS];
  assign o_payload = m_axis_tdata_o[1+RANK_BITS +: PAYLOAD_BITS];
  assign o_count   = m_axis_tdata_o[1+RANK_BITS+PAYLOAD_BITS +: CNT_W];
  assign o_empty   = m_axis_tdata_o[1+RANK_BITS+PAYLOAD_BITS+CNT_W];
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i != '1);

  `SPQ_ASSERT_NOW(a_ready_when_drained, !m_axis_tvalid_o, s_axis_tready_o)
  `SPQ_ASSERT_NOW(a_empty_flag, m_axis_tvalid_o, o_empty == (o_count == '0))
  `SPQ_ASSERT_NOW(a_fail_zero, m_axis_tvalid_o && (o_status == StatusFail), (o_rank == '0) && (o_payload == '0))
  `SPQ_ASSERT_NEXT(a_beat_out, in_beat || (s_axis_tvalid_i && s_axis_tready_o), m_axis_tvalid_o)
  `SPQ_ASSERT_NEXT(a_hold_stall, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY     (CAPACITY),
  .PAYLOAD_BITS (PAYLOAD_BITS),
  .RANK_BITS    (RANK_BITS)
) u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
